### hdl/evup_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// evup_pkg
// Shared types and constants of the Ethernet/VLAN/IPv4/UDP header parser.
// -----------------------------------------------------------------------------
package evup_pkg;

	localparam int unsigned LEN_W               = 16;
	localparam int unsigned DEF_MAX_FRAME_BYTES = 65535;
	localparam logic [15:0] DEF_MATCH_PORT      = 16'd9110;

	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [15:0] ETH_VLAN  = 16'h8100;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [3:0]  IHL_MASK  = 4'h0f;
	localparam logic [6:0]  ETH_HDR   = 7'd14;
	localparam logic [6:0]  VLAN_HDR  = 7'd4;
	localparam logic [6:0]  IP_MIN    = 7'd20;
	localparam logic [6:0]  UDP_HDR   = 7'd8;
	localparam logic [6:0]  POS_TYPE_HI  = 7'd12;
	localparam logic [6:0]  POS_TYPE_LO  = 7'd13;
	localparam logic [6:0]  POS_INNER_HI = 7'd16;
	localparam logic [6:0]  POS_INNER_LO = 7'd17;
	localparam logic [6:0]  IP_PROTO_OFS = 7'd9;

	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_SHORT_ETH     = 4'd1,
		ST_SHORT_VLAN    = 4'd2,
		ST_NOT_IPV4      = 4'd3,
		ST_SHORT_IP      = 4'd4,
		ST_SHORT_UDP     = 4'd5,
		ST_NOT_UDP       = 4'd6,
		ST_UDP_LEN       = 4'd7,
		ST_SHORT_PAYLOAD = 4'd8
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [15:0]      ether_kind;
		logic             vlan_tagged;
		logic [5:0]       ip_hdr_bytes;
		logic [7:0]       ip_proto;
		logic [15:0]      port;
		logic [15:0]      udp_len;
	} frame_t;

endpackage

### hdl/evup_byte_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// evup_byte_if
// Frame byte stream channel: one frame byte and its last-byte mark per word.
// -----------------------------------------------------------------------------
interface evup_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

### hdl/evup_result_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// evup_result_if
// Parse result channel: one word per frame.
// -----------------------------------------------------------------------------
interface evup_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [15:0] dest_port;
	logic [6:0]  payload_start;
	logic [15:0] payload_bytes;
	logic        port_hit;

	modport source (output valid, output status, output dest_port, output payload_start,
		output payload_bytes, output port_hit, input ready);
	modport sink   (input valid, input status, input dest_port, input payload_start,
		input payload_bytes, input port_hit, output ready);
endinterface

### hdl/evup_capture.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// evup_capture
// Per-byte header field capture; snapshots the fields on the last byte.
// -----------------------------------------------------------------------------
module evup_capture import evup_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	input  logic       advance,
	output frame_t     snap_s1,
	output logic       snap_valid_s1
);

	localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      kind_q;
	logic             tagged_q;
	logic [5:0]       ihb_q;
	logic [7:0]       proto_q;
	logic [15:0]      port_q;
	logic [15:0]      ulen_q;

	logic [IDX_W-1:0] idx_d;
	frame_t           nxt;
	logic [LEN_W-1:0] pos;
	logic [6:0]       off;
	logic [6:0]       udp_off;

	always_comb begin
		pos     = LEN_W'(idx_q);
		off     = tagged_q ? (ETH_HDR + VLAN_HDR) : ETH_HDR;
		udp_off = off + 7'(ihb_q);
		idx_d   = idx_q;
		nxt.ether_kind   = kind_q;
		nxt.vlan_tagged  = tagged_q;
		nxt.ip_hdr_bytes = ihb_q;
		nxt.ip_proto     = proto_q;
		nxt.port         = port_q;
		nxt.udp_len      = ulen_q;
		if (idx_q < IDX_W'(MAX_FRAME_BYTES)) begin
			idx_d = idx_q + 1'b1;
			if (pos == LEN_W'(POS_TYPE_LO)) begin
				nxt.ether_kind  = {kind_q[15:8], byte_in};
				nxt.vlan_tagged = ({kind_q[15:8], byte_in} == ETH_VLAN);
			end else begin
				if (pos == LEN_W'(POS_TYPE_HI))
					nxt.ether_kind = {byte_in, 8'h00};
				if (tagged_q && pos == LEN_W'(POS_INNER_HI))
					nxt.ether_kind = {byte_in, kind_q[7:0]};
				if (tagged_q && pos == LEN_W'(POS_INNER_LO))
					nxt.ether_kind = {kind_q[15:8], byte_in};
				if (pos == LEN_W'(off)) begin
					nxt.ip_hdr_bytes = {byte_in[3:0] & IHL_MASK, 2'b00};
				end else if (pos > LEN_W'(off)) begin
					if (pos == LEN_W'(off + IP_PROTO_OFS))
						nxt.ip_proto = byte_in;
					if (pos == LEN_W'(udp_off + 7'd2))
						nxt.port = {byte_in, port_q[7:0]};
					if (pos == LEN_W'(udp_off + 7'd3))
						nxt.port = {port_q[15:8], byte_in};
					if (pos == LEN_W'(udp_off + 7'd4))
						nxt.udp_len = {byte_in, ulen_q[7:0]};
					if (pos == LEN_W'(udp_off + 7'd5))
						nxt.udp_len = {ulen_q[15:8], byte_in};
				end
			end
		end
		nxt.len = LEN_W'(idx_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			kind_q        <= '0;
			tagged_q      <= 1'b0;
			ihb_q         <= '0;
			proto_q       <= '0;
			port_q        <= '0;
			ulen_q        <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (take && last_in) begin
				idx_q    <= '0;
				kind_q   <= '0;
				tagged_q <= 1'b0;
				ihb_q    <= '0;
				proto_q  <= '0;
				port_q   <= '0;
				ulen_q   <= '0;
			end else if (take) begin
				idx_q    <= idx_d;
				kind_q   <= nxt.ether_kind;
				tagged_q <= nxt.vlan_tagged;
				ihb_q    <= nxt.ip_hdr_bytes;
				proto_q  <= nxt.ip_proto;
				port_q   <= nxt.port;
				ulen_q   <= nxt.udp_len;
			end
			snap_valid_s1 <= (take && last_in) || (snap_valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_in)
			snap_s1 <= nxt;
	end

endmodule

### hdl/evup_judge.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// evup_judge
// Frame checks in priority order and the registered result word.
// -----------------------------------------------------------------------------
module evup_judge import evup_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  frame_t       snap_s1,
	input  logic         snap_valid_s1,
	input  logic [15:0]  match_port,
	output logic         advance,
	evup_result_if.source res
);

	logic        valid_q;
	status_t     status_q;
	logic [15:0] port_q;
	logic [6:0]  start_q;
	logic [15:0] bytes_q;
	logic        hit_q;

	status_t     st;
	logic [6:0]  off;
	logic [6:0]  udp_off;
	logic [16:0] need;

	always_comb begin
		off     = snap_s1.vlan_tagged ? (ETH_HDR + VLAN_HDR) : ETH_HDR;
		udp_off = off + 7'(snap_s1.ip_hdr_bytes);
		need    = 17'(udp_off) + 17'(snap_s1.udp_len);
		if (snap_s1.len < LEN_W'(ETH_HDR))
			st = ST_SHORT_ETH;
		else if (snap_s1.vlan_tagged && snap_s1.len < LEN_W'(ETH_HDR + VLAN_HDR))
			st = ST_SHORT_VLAN;
		else if (snap_s1.ether_kind != ETH_IPV4)
			st = ST_NOT_IPV4;
		else if (snap_s1.len < LEN_W'(off + IP_MIN))
			st = ST_SHORT_IP;
		else if (snap_s1.len < LEN_W'(udp_off + UDP_HDR))
			st = ST_SHORT_UDP;
		else if (snap_s1.ip_proto != PROTO_UDP)
			st = ST_NOT_UDP;
		else if (snap_s1.udp_len < 16'(UDP_HDR))
			st = ST_UDP_LEN;
		else if ({1'b0, snap_s1.len} < need)
			st = ST_SHORT_PAYLOAD;
		else
			st = ST_OK;
	end

	assign advance = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= snap_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && snap_valid_s1) begin
			status_q <= st;
			port_q   <= (st == ST_OK || st == ST_UDP_LEN || st == ST_SHORT_PAYLOAD) ?
				snap_s1.port : 16'h0000;
			start_q  <= (st == ST_OK) ? (udp_off + UDP_HDR) : 7'd0;
			bytes_q  <= (st == ST_OK) ? (snap_s1.udp_len - 16'(UDP_HDR)) : 16'h0000;
			hit_q    <= (st == ST_OK) && (snap_s1.port == match_port);
		end
	end

	assign res.valid         = valid_q;
	assign res.status        = status_q;
	assign res.dest_port     = port_q;
	assign res.payload_start = start_q;
	assign res.payload_bytes = bytes_q;
	assign res.port_hit      = hit_q;

endmodule

### hdl/eth_vlan_ipv4_udp_header_parser_top.sv
`timescale 1ns / 1ps
// The last byte's fields go to the snapshot stage, then the result word to the output register.
// Throughput: one frame byte per cycle while ready is high; one result word per frame.
// Ready drops only while a finished result waits in both the snapshot and output stages.
// Reset (arst_n low, asynchronous): frame state and valids clear, match port = 9110.
// -----------------------------------------------------------------------------
// eth_vlan_ipv4_udp_header_parser_top
// Streaming Ethernet/802.1Q/IPv4/UDP header parser with destination port match.
// -----------------------------------------------------------------------------
module eth_vlan_ipv4_udp_header_parser_top import evup_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	evup_byte_if.sink    in_chan,
	evup_result_if.source out_chan,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data
);

	logic [15:0] match_port_q;
	frame_t      snap_s1;
	logic        snap_valid_s1;
	logic        advance;
	logic        take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			match_port_q <= DEF_MATCH_PORT;
		else if (cfg_wr_en)
			match_port_q <= cfg_wr_data;
	end

	assign in_chan.ready = !snap_valid_s1 || advance;
	assign take          = in_chan.valid && in_chan.ready;

	evup_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.byte_in      (in_chan.frame_byte),
		.last_in      (in_chan.frame_last),
		.advance      (advance),
		.snap_s1      (snap_s1),
		.snap_valid_s1(snap_valid_s1)
	);

	evup_judge u_judge (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_s1      (snap_s1),
		.snap_valid_s1(snap_valid_s1),
		.match_port   (match_port_q),
		.advance      (advance),
		.res          (out_chan)
	);

endmodule

### hdl/evup_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// evup_checker
// Port-level checks of the header parser, bound to the top level.
// -----------------------------------------------------------------------------
module evup_checker import evup_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [15:0] dest_port,
	input logic [6:0]  payload_start,
	input logic [15:0] payload_bytes,
	input logic        port_hit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(dest_port)
			&& $stable(payload_start) && $stable(payload_bytes) && $stable(port_hit))
		else $error("result word changed while stalled");

	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> payload_start == 7'd0 && payload_bytes == 16'h0000
			&& !port_hit)
		else $error("payload fields set on a failed frame");

	a_early_port: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status >= ST_SHORT_ETH && status <= ST_NOT_UDP |-> dest_port == 16'h0000)
		else $error("port reported before the UDP header was reached");

	a_ok_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> payload_start >= (ETH_HDR + UDP_HDR)
			&& payload_start <= 7'd86)
		else $error("payload start out of range");

endmodule

bind eth_vlan_ipv4_udp_header_parser_top evup_checker u_evup_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_chan.ready),
	.out_valid    (out_chan.valid),
	.out_ready    (out_chan.ready),
	.status       (out_chan.status),
	.dest_port    (out_chan.dest_port),
	.payload_start(out_chan.payload_start),
	.payload_bytes(out_chan.payload_bytes),
	.port_hit     (out_chan.port_hit)
);
